// ===== rtl/irt_pkg.sv =====
// ----------------------------------------------------------------------------
// irt_pkg: shared types and constants of the IR remote frame transmitter
// Item classes, the queued command word, the bit-engine state codes, timing
// constants and the pause-length lookup.
// ----------------------------------------------------------------------------
package irt_pkg;

    // Action codes on the input item
    localparam logic [2:0] ACT_TICK  = 3'd0;
    localparam logic [2:0] ACT_PWM   = 3'd1;
    localparam logic [2:0] ACT_INC   = 3'd2;
    localparam logic [2:0] ACT_DEC   = 3'd3;
    localparam logic [2:0] ACT_COMBO = 3'd4;

    // Timing, in carrier half periods
    localparam logic [3:0] PULSES_PER_BIT    = 4'd6;
    localparam logic [7:0] LOW_SPACE_TICKS   = 8'd20;
    localparam logic [7:0] HIGH_SPACE_TICKS  = 8'd42;
    localparam logic [7:0] START_SPACE_TICKS = 8'd78;
    localparam logic [7:0] PAUSE_UNIT_TICKS  = 8'd6;
    localparam logic [2:0] REPEATS           = 3'd6;

    // Frame constants
    localparam logic [3:0] CHECK_SEED  = 4'hF;
    localparam logic [2:0] PWM_N2_BASE = 3'b010;
    localparam logic [2:0] STEP_N2_BASE = 3'b011;
    localparam logic [3:0] INC_NIBBLE  = 4'h4;
    localparam logic [3:0] DEC_NIBBLE  = 4'h5;
    localparam logic [1:0] COMBO_N1_HI = 2'b01;
    localparam logic [4:0] STOP_INDEX  = 5'd17;
    localparam logic [4:0] DATA_BITS   = 5'd16;

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Item class decided by the front end
    typedef enum logic [1:0] {
        K_TICK   = 2'd0,
        K_SINGLE = 2'd1,
        K_COMBO  = 2'd2,
        K_NOP    = 2'd3
    } kind_t;

    // Classified item as it travels through the queue
    typedef struct packed {
        kind_t      kind;
        logic [3:0] n2;
        logic [3:0] n3;
    } cmd_t;

    // Bit-engine phase, one-hot
    typedef enum logic [4:0] {
        PH_IDLE  = 5'b00001,
        PH_PAUSE = 5'b00010,
        PH_HIGH  = 5'b00100,
        PH_LOW   = 5'b01000,
        PH_SPACE = 5'b10000
    } phase_t;

    // Pause length in units ahead of a frame copy
    function automatic logic [3:0] pause_units(input logic [2:0] rep, input logic [1:0] ch);
        logic [3:0] units;
        if (rep == 3'd0)
            units = 4'd3 - {2'b00, ch};
        else if (rep < 3'd3)
            units = 4'd5;
        else
            units = 4'd8 + {1'b0, ch, 1'b0};
        return units;
    endfunction

endpackage

// ===== rtl/irt_queue.sv =====
// ----------------------------------------------------------------------------
// irt_queue: small FIFO of classified items
// Register-based ring buffer between the front end and the bit engine.
// ----------------------------------------------------------------------------
module irt_queue #(
    parameter int DEPTH = irt_pkg::QUEUE_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  irt_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          not_empty,
    output irt_pkg::cmd_t head_cmd
);
    import irt_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    cmd_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == FULL_CNT);
    assign not_empty = (count_reg != '0);
    assign head_cmd  = entry_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

// ===== rtl/irt_front.sv =====
// ----------------------------------------------------------------------------
// irt_front: input side of the transmitter
// Takes input items, sorts them into tick, single, combo or no-op, builds
// the nibbles that do not depend on engine state, and queues them.
// ----------------------------------------------------------------------------
module irt_front #(
    parameter int DEPTH = irt_pkg::QUEUE_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [2:0]    action,
    input  logic          output_select,
    input  logic [3:0]    pwm_step,
    input  logic [3:0]    combo_blue,
    input  logic [3:0]    combo_red,
    output logic          q_valid,
    output irt_pkg::cmd_t q_cmd,
    input  logic          q_pop
);
    import irt_pkg::*;

    cmd_t cls_cmd;
    logic q_full;

    // Action decoder
    always_comb
    begin
        cls_cmd.kind = K_NOP;
        cls_cmd.n2   = '0;
        cls_cmd.n3   = '0;
        unique case (action)
            ACT_TICK:
            begin
                cls_cmd.kind = K_TICK;
            end
            ACT_PWM:
            begin
                cls_cmd.kind = K_SINGLE;
                cls_cmd.n2   = {PWM_N2_BASE, output_select};
                cls_cmd.n3   = pwm_step;
            end
            ACT_INC:
            begin
                cls_cmd.kind = K_SINGLE;
                cls_cmd.n2   = {STEP_N2_BASE, output_select};
                cls_cmd.n3   = INC_NIBBLE;
            end
            ACT_DEC:
            begin
                cls_cmd.kind = K_SINGLE;
                cls_cmd.n2   = {STEP_N2_BASE, output_select};
                cls_cmd.n3   = DEC_NIBBLE;
            end
            ACT_COMBO:
            begin
                cls_cmd.kind = K_COMBO;
                cls_cmd.n2   = combo_blue;
                cls_cmd.n3   = combo_red;
            end
            default:
            begin
                cls_cmd.kind = K_NOP;
            end
        endcase
    end

    assign in_ready = !q_full;

    irt_queue #(
        .DEPTH (DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_valid && !q_full),
        .push_cmd  (cls_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .head_cmd  (q_cmd)
    );

endmodule

// ===== rtl/irt_back.sv =====
// ----------------------------------------------------------------------------
// irt_back: frame engine of the transmitter
// Pulls one queued item per cycle unless out_ready stalls, runs the pause /
// mark / space sequencer, builds command frames and registers the result item.
// ----------------------------------------------------------------------------
module irt_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    input  irt_pkg::cmd_t q_cmd,
    output logic          q_pop,
    input  logic          cfg_wr_en,
    input  logic [1:0]    cfg_wr_data,
    output logic          out_valid,
    input  logic          out_ready,
    output logic          ir_level,
    output logic          busy_res,
    output logic          rejected
);
    import irt_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [1:0]  channel_reg;
    logic        toggle_reg, toggle_next;
    logic [15:0] frame_reg, frame_next;
    logic [2:0]  rep_reg, rep_next;
    logic [4:0]  bit_reg, bit_next;
    logic [3:0]  pulse_reg, pulse_next;
    logic [7:0]  space_reg, space_next;
    logic        out_valid_reg;
    logic        level_reg, level_next;
    logic        busy_reg;
    logic        rej_reg, rej_next;

    logic        take;
    logic        start_copy;
    logic [2:0]  copy_rep;
    logic [3:0]  units;
    logic [3:0]  n1;
    logic [3:0]  pulse_inc;
    logic [2:0]  rep_inc;
    logic [7:0]  space_dec;
    logic [7:0]  mark_space;
    logic [3:0]  bit_pos;

    assign take  = q_valid && (!out_valid_reg || out_ready);
    assign q_pop = take;

    // Helpers for the sequencer
    assign pulse_inc = pulse_reg + 4'd1;
    assign rep_inc   = rep_reg + 3'd1;
    assign space_dec = space_reg - 8'd1;
    assign bit_pos   = 4'(DATA_BITS - bit_reg);
    assign units     = pause_units(copy_rep, channel_reg);
    assign n1        = (q_cmd.kind == K_COMBO) ? {COMBO_N1_HI, channel_reg}
                                               : {toggle_reg, 1'b0, channel_reg};

    // Space after the current mark: start and stop marks are long
    always_comb
    begin
        if (bit_reg == 5'd0 || bit_reg >= STOP_INDEX)
            mark_space = START_SPACE_TICKS;
        else if (frame_reg[bit_pos])
            mark_space = HIGH_SPACE_TICKS;
        else
            mark_space = LOW_SPACE_TICKS;
    end

    // Sequencer next state for the item at the queue head
    always_comb
    begin
        phase_next  = phase_reg;
        toggle_next = toggle_reg;
        frame_next  = frame_reg;
        rep_next    = rep_reg;
        bit_next    = bit_reg;
        pulse_next  = pulse_reg;
        space_next  = space_reg;
        level_next  = 1'b0;
        rej_next    = 1'b0;
        start_copy  = 1'b0;
        copy_rep    = 3'd0;

        case (q_cmd.kind)
            K_TICK:
            begin
                unique case (phase_reg)
                    PH_PAUSE:
                    begin
                        space_next = space_dec;
                        if (space_dec == 8'd0)
                            phase_next = PH_HIGH;
                    end
                    PH_HIGH:
                    begin
                        level_next = 1'b1;
                        phase_next = PH_LOW;
                    end
                    PH_LOW:
                    begin
                        if (pulse_inc >= PULSES_PER_BIT)
                        begin
                            pulse_next = 4'd0;
                            space_next = mark_space;
                            phase_next = PH_SPACE;
                        end
                        else
                        begin
                            pulse_next = pulse_inc;
                            phase_next = PH_HIGH;
                        end
                    end
                    PH_SPACE:
                    begin
                        space_next = space_dec;
                        if (space_dec == 8'd0)
                        begin
                            if (bit_reg >= STOP_INDEX)
                            begin
                                if (rep_inc >= REPEATS)
                                begin
                                    rep_next   = 3'd0;
                                    bit_next   = 5'd0;
                                    phase_next = PH_IDLE;
                                end
                                else
                                begin
                                    rep_next   = rep_inc;
                                    start_copy = 1'b1;
                                    copy_rep   = rep_inc;
                                end
                            end
                            else
                            begin
                                bit_next   = bit_reg + 5'd1;
                                phase_next = PH_HIGH;
                            end
                        end
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
            K_SINGLE, K_COMBO:
            begin
                if (phase_reg != PH_IDLE)
                begin
                    rej_next = 1'b1;
                end
                else
                begin
                    frame_next = {n1, q_cmd.n2, q_cmd.n3, CHECK_SEED ^ n1 ^ q_cmd.n2 ^ q_cmd.n3};
                    if (q_cmd.kind == K_SINGLE)
                        toggle_next = !toggle_reg;
                    rep_next   = 3'd0;
                    start_copy = 1'b1;
                    copy_rep   = 3'd0;
                end
            end
            default:
            begin
            end
        endcase

        // Start of a frame copy: pause, skipped when zero units long
        if (start_copy)
        begin
            bit_next   = 5'd0;
            pulse_next = 4'd0;
            if (units == 4'd0)
            begin
                space_next = 8'd0;
                phase_next = PH_HIGH;
            end
            else
            begin
                space_next = 8'({4'b0000, units} * PAUSE_UNIT_TICKS);
                phase_next = PH_PAUSE;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            channel_reg   <= 2'd0;
            toggle_reg    <= 1'b0;
            frame_reg     <= 16'd0;
            rep_reg       <= 3'd0;
            bit_reg       <= 5'd0;
            pulse_reg     <= 4'd0;
            space_reg     <= 8'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                channel_reg <= cfg_wr_data;
            if (take)
            begin
                phase_reg  <= phase_next;
                toggle_reg <= toggle_next;
                frame_reg  <= frame_next;
                rep_reg    <= rep_next;
                bit_reg    <= bit_next;
                pulse_reg  <= pulse_next;
                space_reg  <= space_next;
            end
            if (take)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            level_reg <= level_next;
            busy_reg  <= (phase_next != PH_IDLE);
            rej_reg   <= rej_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign ir_level  = level_reg;
    assign busy_res  = busy_reg;
    assign rejected  = rej_reg;

endmodule

// ===== rtl/ir_remote_frame_transmitter.sv =====
// Each accepted input item passes through the queue, then the result register.
// Throughput: the engine retires one queued item a cycle unless out_ready stalls it.
// A short queue decouples input acceptance from the registered result stage.
// Reset (rst_n low, asynchronous): engine idle, toggle bit, channel and queue cleared.
// ----------------------------------------------------------------------------
// ir_remote_frame_transmitter: infrared remote-control frame transmitter
// Builds 16-bit pulse-distance frames from commands and steps them out one
// carrier half period per tick item on the emitter level.
// ----------------------------------------------------------------------------
module ir_remote_frame_transmitter #(
    parameter int QUEUE_DEPTH = irt_pkg::QUEUE_DEPTH
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [2:0] action,
    input  logic       output_select,
    input  logic [3:0] pwm_step,
    input  logic [3:0] combo_blue,
    input  logic [3:0] combo_red,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       ir_level,
    output logic       busy_res,
    output logic       rejected,
    input  logic       cfg_wr_en,
    input  logic [1:0] cfg_wr_data
);
    import irt_pkg::*;

    logic q_valid;
    cmd_t q_cmd;
    logic q_pop;

    // Front end: classify and queue
    irt_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .action        (action),
        .output_select (output_select),
        .pwm_step      (pwm_step),
        .combo_blue    (combo_blue),
        .combo_red     (combo_red),
        .q_valid       (q_valid),
        .q_cmd         (q_cmd),
        .q_pop         (q_pop)
    );

    // Back end: frame engine and result register
    irt_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_cmd       (q_cmd),
        .q_pop       (q_pop),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .ir_level    (ir_level),
        .busy_res    (busy_res),
        .rejected    (rejected)
    );

    // A rejected command never drives the emitter
    a_rej_no_level: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && rejected |-> !ir_level)
        else $error("rejected item with emitter high");

    // The emitter is only driven while a frame is in flight
    a_level_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ir_level |-> busy_res)
        else $error("emitter high while idle");

    // The engine only pulls items that are queued
    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("queue popped while empty");

    // A result taken with nothing pending behind it leaves the output empty
    a_out_drain: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !q_valid |=> !out_valid)
        else $error("result item repeated");

endmodule

// ===== tb/tb_ir_remote_frame_transmitter.sv =====
// ----------------------------------------------------------------------------
// tb_ir_remote_frame_transmitter: regression bench for the IR frame transmitter
// Drives command and tick items through the valid/ready input, predicts the
// emitter level, busy flag and reject flag of every item with an in-bench
// model of the frame engine, and checks each result item against the oldest
// prediction. One frame runs to its end with a channel change in mid-frame,
// each copy under another sender and receiver idling pattern.
// ----------------------------------------------------------------------------
module tb_ir_remote_frame_transmitter;
    import irt_pkg::*;

    // Frame timing, in ticks
    localparam logic [3:0] MARK_PULSES  = 4'd6;
    localparam logic [7:0] ZERO_SPACE   = 8'd20;
    localparam logic [7:0] ONE_SPACE    = 8'd42;
    localparam logic [7:0] FRAME_SPACE  = 8'd78;
    localparam logic [7:0] PAUSE_TICKS  = 8'd6;
    localparam logic [2:0] FRAME_COPIES = 3'd6;
    localparam logic [4:0] LAST_MARK    = 5'd17;

    // Action codes the block ignores
    localparam logic [2:0] ACT_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] ACT_UNUSED_LAST  = 3'd7;

    // Idling patterns
    localparam int IDLE_NONE   = 0;
    localparam int IDLE_SENDER = 1;
    localparam int IDLE_SINK   = 2;
    localparam int IDLE_BOTH   = 3;

    typedef struct packed {
        logic ir_level;
        logic busy;
        logic rejected;
    } pin_state_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [2:0] action = ACT_TICK;
    logic       output_select = 1'b0;
    logic [3:0] pwm_step = 4'd0;
    logic [3:0] combo_blue = 4'd0;
    logic [3:0] combo_red = 4'd0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic       ir_level;
    logic       busy_res;
    logic       rejected;
    logic       cfg_wr_en = 1'b0;
    logic [1:0] cfg_wr_data = 2'd0;

    // Predicted transmitter state
    logic [1:0]  tx_chan = 2'd0;
    logic        tx_toggle = 1'b0;
    logic [15:0] tx_frame = 16'd0;
    logic [2:0]  tx_copy = 3'd0;
    logic [4:0]  tx_mark = 5'd0;
    phase_t      tx_phase = PH_IDLE;
    logic [3:0]  tx_pulses = 4'd0;
    logic [7:0]  tx_space = 8'd0;

    pin_state_t pin_q[$];
    int error_count = 0;
    int src_idle_pct = 0;
    int sink_stall_pct = 0;

    ir_remote_frame_transmitter uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .output_select(output_select),
        .pwm_step     (pwm_step),
        .combo_blue   (combo_blue),
        .combo_red    (combo_red),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .ir_level     (ir_level),
        .busy_res     (busy_res),
        .rejected     (rejected),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data)
    );

    // Clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Frame engine prediction
    // ------------------------------------------------------------------

    // Pause ahead of a frame copy, then the start mark
    function automatic void start_copy();
        logic [3:0] units;
        if (tx_copy == 3'd0)
            units = 4'd3 - {2'b00, tx_chan};
        else if (tx_copy < 3'd3)
            units = 4'd5;
        else
            units = 4'd6 + 4'(2 * (tx_chan + 1));
        tx_mark = 5'd0;
        tx_pulses = 4'd0;
        if (units == 4'd0)
        begin
            tx_space = 8'd0;
            tx_phase = PH_HIGH;
        end
        else
        begin
            tx_space = 8'(units * PAUSE_TICKS);
            tx_phase = PH_PAUSE;
        end
    endfunction

    // Space that follows the current mark
    function automatic logic [7:0] mark_space();
        if (tx_mark == 5'd0 || tx_mark >= LAST_MARK)
            return FRAME_SPACE;
        return tx_frame[5'd16 - tx_mark] ? ONE_SPACE : ZERO_SPACE;
    endfunction

    // One carrier half period; returns the emitter level
    function automatic logic tick_engine();
        logic level;
        level = 1'b0;
        case (tx_phase)
            PH_PAUSE:
            begin
                tx_space = tx_space - 8'd1;
                if (tx_space == 8'd0)
                    tx_phase = PH_HIGH;
            end
            PH_HIGH:
            begin
                level = 1'b1;
                tx_phase = PH_LOW;
            end
            PH_LOW:
            begin
                tx_pulses = tx_pulses + 4'd1;
                if (tx_pulses >= MARK_PULSES)
                begin
                    tx_pulses = 4'd0;
                    tx_space = mark_space();
                    tx_phase = PH_SPACE;
                end
                else
                    tx_phase = PH_HIGH;
            end
            PH_SPACE:
            begin
                tx_space = tx_space - 8'd1;
                if (tx_space == 8'd0)
                begin
                    if (tx_mark >= LAST_MARK)
                    begin
                        tx_copy = tx_copy + 3'd1;
                        if (tx_copy >= FRAME_COPIES)
                        begin
                            tx_copy = 3'd0;
                            tx_mark = 5'd0;
                            tx_phase = PH_IDLE;
                        end
                        else
                            start_copy();
                    end
                    else
                    begin
                        tx_mark = tx_mark + 5'd1;
                        tx_phase = PH_HIGH;
                    end
                end
            end
            default:
                tx_phase = PH_IDLE;
        endcase
        return level;
    endfunction

    // Pin state that one accepted item leaves behind
    function automatic pin_state_t apply_item(input logic [2:0] act, input logic sel,
                                              input logic [3:0] pwm, input logic [3:0] blue,
                                              input logic [3:0] red);
        pin_state_t res;
        logic [3:0] n1, n2, n3;
        res = '0;
        if (act == ACT_TICK)
            res.ir_level = tick_engine();
        else if (act <= ACT_COMBO)
        begin
            if (tx_phase != PH_IDLE)
                res.rejected = 1'b1;
            else
            begin
                if (act == ACT_COMBO)
                begin
                    n1 = {2'b01, tx_chan};
                    n2 = blue;
                    n3 = red;
                end
                else
                begin
                    n1 = {tx_toggle, 1'b0, tx_chan};
                    n2 = (act == ACT_PWM) ? {3'b010, sel} : {3'b011, sel};
                    n3 = (act == ACT_PWM) ? pwm : ((act == ACT_INC) ? 4'h4 : 4'h5);
                    tx_toggle = ~tx_toggle;
                end
                tx_frame = {n1, n2, n3, 4'hF ^ n1 ^ n2 ^ n3};
                tx_copy = 3'd0;
                start_copy();
            end
        end
        res.busy = (tx_phase != PH_IDLE);
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    task automatic check_bit(input string name, input logic want, input logic got);
        if (got !== want)
        begin
            $error("%s: expected %0b, got %0b", name, want, got);
            error_count++;
        end
    endtask

    always @(posedge clk)
    begin : result_check
        pin_state_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pin_q.size() == 0)
            begin
                $error("result item with no item pending");
                error_count++;
            end
            else
            begin
                want = pin_q.pop_front();
                check_bit("ir_level", want.ir_level, ir_level);
                check_bit("busy_res", want.busy, busy_res);
                check_bit("rejected", want.rejected, rejected);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    task automatic set_idling(input int mode);
        case (mode)
            IDLE_NONE:   begin src_idle_pct = 0;  sink_stall_pct = 0;  end
            IDLE_SENDER: begin src_idle_pct = 56; sink_stall_pct = 0;  end
            IDLE_SINK:   begin src_idle_pct = 0;  sink_stall_pct = 56; end
            default:     begin src_idle_pct = 16; sink_stall_pct = 16; end
        endcase
    endtask

    // Send one item; valid stays up after acceptance until the next gap
    task automatic send_item(input logic [2:0] act, input logic sel, input logic [3:0] pwm,
                             input logic [3:0] blue, input logic [3:0] red);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        action        <= act;
        output_select <= sel;
        pwm_step      <= pwm;
        combo_blue    <= blue;
        combo_red     <= red;
        do
            @(posedge clk);
        while (!in_ready);
        pin_q.push_back(apply_item(act, sel, pwm, blue, red));
    endtask

    task automatic send_random_fields(input logic [2:0] act);
        send_item(act, 1'($urandom), 4'($urandom), 4'($urandom), 4'($urandom));
    endtask

    // Let every pending result arrive, plus the pipeline latency
    task automatic wait_all_results();
        in_valid <= 1'b0;
        while (pin_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_channel(input logic [1:0] chan);
        wait_all_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= chan;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        tx_chan = chan;
    endtask

    // Tick until the frame ends, with stray commands and unused codes mixed in
    task automatic play_out_frame(input bit swap_channel, input logic [1:0] next_chan);
        bit swapped;
        int r;
        swapped = 1'b0;
        while (tx_phase != PH_IDLE)
        begin
            // each copy runs under the next idling pattern
            set_idling(int'(tx_copy) % 4);
            // channel change once the second copy has started
            if (swap_channel && !swapped && tx_copy == 3'd1)
            begin
                write_channel(next_chan);
                swapped = 1'b1;
            end
            r = $urandom_range(0, 199);
            if (r == 0)
                send_random_fields(3'($urandom_range(ACT_UNUSED_FIRST, ACT_UNUSED_LAST)));
            else if (r < 4)
                send_random_fields(3'($urandom_range(ACT_PWM, ACT_COMBO)));
            else
                send_random_fields(ACT_TICK);
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Ticks and unused codes while idle change nothing
    task automatic test_idle_items();
        int a;
        set_idling(IDLE_NONE);
        send_item(ACT_TICK, 1'b1, 4'hF, 4'hF, 4'hF);
        for (a = ACT_UNUSED_FIRST; a <= ACT_UNUSED_LAST; a++)
        begin
            send_item(3'(a), 1'b1, 4'hF, 4'hF, 4'hF);
            send_item(3'(a), 1'b0, 4'h0, 4'h0, 4'h0);
        end
        send_item(ACT_TICK, 1'b0, 4'h0, 4'h0, 4'h0);
    endtask

    // Channel 3 skips the first pause; every command is dropped while busy
    task automatic test_busy_rejects();
        write_channel(2'd3);
        send_item(ACT_PWM, 1'b1, 4'hF, 4'h0, 4'h0);
        send_item(ACT_PWM, 1'b0, 4'h0, 4'hF, 4'hF);
        send_item(ACT_INC, 1'b1, 4'h0, 4'h0, 4'h0);
        send_item(ACT_DEC, 1'b0, 4'hF, 4'hF, 4'hF);
        send_item(ACT_COMBO, 1'b1, 4'hF, 4'h0, 4'hF);
        send_item(ACT_UNUSED_LAST, 1'b1, 4'hF, 4'hF, 4'hF);
        repeat (8) send_random_fields(ACT_TICK);
        send_item(ACT_COMBO, 1'b0, 4'h0, 4'hF, 4'h0);
    endtask

    // The frame in flight runs through all its copies and back to idle,
    // with the channel moved to 1 after the first copy
    task automatic test_full_frames();
        play_out_frame(1'b1, 2'd1);
    endtask

    // Mostly command-then-ticks traffic with random content
    task automatic test_random_traffic();
        int p, n, r;
        for (p = IDLE_NONE; p <= IDLE_BOTH; p++)
        begin
            write_channel(2'($urandom_range(0, 3)));
            set_idling(p);
            for (n = 0; n < 100; n++)
            begin
                r = $urandom_range(0, 99);
                if (tx_phase == PH_IDLE && r < 80)
                    send_random_fields(3'($urandom_range(ACT_PWM, ACT_COMBO)));
                else if (r < 90)
                    send_random_fields(ACT_TICK);
                else if (r < 95 && tx_phase != PH_IDLE)
                    send_random_fields(3'($urandom_range(ACT_PWM, ACT_COMBO)));
                else
                    send_random_fields(3'($urandom_range(ACT_UNUSED_FIRST, ACT_UNUSED_LAST)));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial
    begin
        int n;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_idle_items();
        test_busy_rejects();
        test_full_frames();
        test_random_traffic();

        // drain, then allow for the pipeline latency
        in_valid <= 1'b0;
        for (n = 0; n < 100000 && pin_q.size() != 0; n++)
            @(posedge clk);
        if (pin_q.size() != 0)
        begin
            $error("%0d result items never arrived", pin_q.size());
            error_count++;
        end
        repeat (10) @(posedge clk);

        if (error_count == 0)
            $display("ir_remote_frame_transmitter regression: pass");
        else
            $display("ir_remote_frame_transmitter regression: fail");
        $finish;
    end

    // Watchdog
    initial
    begin
        #10000000;
        $display("ir_remote_frame_transmitter regression: fail");
        $finish;
    end

endmodule
